/* hdl/dwv_pkg.sv */
// Shared types, register indexes and helper functions of the decimal word verifier.
package dwv_pkg;

    localparam int DEFAULT_MAX_COUNT = 63;
    localparam int DEFAULT_Q_DEPTH   = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int SIG_W      = 6;
    localparam int SIG_MAX    = 63;

    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_LZ   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMPLIED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INCR_CODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIGITS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIGITS = 3'd4;

    localparam logic [1:0] INCR_0_01   = 2'd0;
    localparam logic [1:0] INCR_0_001  = 2'd1;
    localparam logic [1:0] INCR_0_0001 = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        CC_NONZERO,
        CC_ZERO,
        CC_POINT,
        CC_SIGN,
        CC_OTHER
    } t_char_class;

    typedef struct packed {
        t_char_class cls;
        logic        last;
    } t_char_item;

    typedef struct packed {
        logic             word_valid;
        logic             point_seen;
        logic [SIG_W-1:0] significant_digits;
    } t_result;

    typedef struct packed {
        logic                  allow_lz;
        logic                  implied;
        logic [1:0]            incr_code;
        logic [CFG_DATA_W-1:0] max_digits;
        logic [CFG_DATA_W-1:0] min_digits;
    } t_cfg;

    function automatic t_char_class classify(input logic [7:0] ch);
        t_char_class c;
        if (ch >= CH_ONE && ch <= CH_NINE) begin
            c = CC_NONZERO;
        end else if (ch == CH_ZERO) begin
            c = CC_ZERO;
        end else if (ch == CH_POINT) begin
            c = CC_POINT;
        end else if (ch == CH_PLUS || ch == CH_MINUS) begin
            c = CC_SIGN;
        end else begin
            c = CC_OTHER;
        end
        return c;
    endfunction

    // fraction digit limit; 0 = unsupported increment
    function automatic logic [2:0] frac_limit(input logic [1:0] code);
        logic [2:0] lim;
        case (code)
            INCR_0_01:   lim = 3'd2;
            INCR_0_001:  lim = 3'd3;
            INCR_0_0001: lim = 3'd4;
            default:     lim = 3'd0;
        endcase
        return lim;
    endfunction

endpackage

/* hdl/dwv_fifo.sv */
// Small synchronous request queue used between the stages of the verifier.
module dwv_fifo import dwv_pkg::*; #(
    parameter int WIDTH = 4,
    parameter int DEPTH = DEFAULT_Q_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* hdl/dwv_front.sv */
// Front end: takes characters, classifies them and hands them to the work queue.
module dwv_front import dwv_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_full,
    output logic       o_q_push,
    output t_char_item o_q_item,
    input  logic       i_q_full
);
    logic       r_vld;
    t_char_item r_item;
    logic       accept;

    assign o_q_push = r_vld && !i_q_full;
    assign o_full   = r_vld && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_item = r_item;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.cls  <= classify(i_char_code);
            r_item.last <= i_last_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_q_push) begin
            r_vld <= 1'b0;
        end
    end

endmodule

/* hdl/dwv_back.sv */
// Back end: word counters, end-of-word snapshot and format judgement.
module dwv_back import dwv_pkg::*; #(
    parameter int MAX_COUNT = DEFAULT_MAX_COUNT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_q_empty,
    input  t_char_item i_q_item,
    output logic       o_q_pop,
    output logic       o_res_push,
    output t_result    o_res,
    input  logic       i_res_full
);
    localparam int CW = $clog2(MAX_COUNT + 1);

    typedef struct packed {
        logic          err;
        logic          pt;
        logic [CW-1:0] lz;
        logic [CW-1:0] tz;
        logic [CW-1:0] dc;
        logic [CW-1:0] idc;
    } t_snap;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (v >= CW'(MAX_COUNT)) ? CW'(MAX_COUNT) : v + 1'b1;
    endfunction

    function automatic logic [CW-1:0] sat_sub(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    // word state
    logic          r_err, r_first, r_pt;
    logic [CW-1:0] r_lz, r_tz, r_nz, r_dc, r_idc;
    logic          n_err, n_pt;
    logic [CW-1:0] n_lz, n_tz, n_nz, n_dc, n_idc;

    logic  r_snap_vld;
    t_snap r_snap;
    logic  take;

    assign o_res_push = r_snap_vld && !i_res_full;
    assign take       = !i_q_empty && (!r_snap_vld || !i_res_full);
    assign o_q_pop    = take;

    always_comb begin
        n_err = r_err;
        n_pt  = r_pt;
        n_lz  = r_lz;
        n_tz  = r_tz;
        n_nz  = r_nz;
        n_dc  = r_dc;
        n_idc = r_idc;
        case (i_q_item.cls)
            CC_NONZERO: begin
                if (r_pt) begin
                    n_tz = '0;
                end
                n_nz = sat_inc(r_nz);
                n_dc = sat_inc(r_dc);
            end
            CC_ZERO: begin
                if (!r_pt) begin
                    if (r_nz == '0) begin
                        n_lz = sat_inc(r_lz);
                    end
                end else begin
                    n_tz = sat_inc(r_tz);
                end
                n_dc = sat_inc(r_dc);
            end
            CC_POINT: begin
                if (r_pt) begin
                    n_err = 1'b1;
                end else begin
                    n_pt  = 1'b1;
                    n_idc = sat_sub(r_dc, r_lz);
                end
            end
            CC_SIGN: begin
                if (!r_first) begin
                    n_err = 1'b1;
                end
            end
            default: begin
                n_err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (take && i_q_item.last) begin
            r_snap.err <= n_err;
            r_snap.pt  <= n_pt;
            r_snap.lz  <= n_lz;
            r_snap.tz  <= n_tz;
            r_snap.dc  <= n_dc;
            r_snap.idc <= n_idc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err      <= 1'b0;
            r_first    <= 1'b1;
            r_pt       <= 1'b0;
            r_lz       <= '0;
            r_tz       <= '0;
            r_nz       <= '0;
            r_dc       <= '0;
            r_idc      <= '0;
            r_snap_vld <= 1'b0;
        end else begin
            if (take) begin
                if (i_q_item.last) begin
                    r_err   <= 1'b0;
                    r_first <= 1'b1;
                    r_pt    <= 1'b0;
                    r_lz    <= '0;
                    r_tz    <= '0;
                    r_nz    <= '0;
                    r_dc    <= '0;
                    r_idc   <= '0;
                end else begin
                    r_err   <= n_err;
                    r_first <= 1'b0;
                    r_pt    <= n_pt;
                    r_lz    <= n_lz;
                    r_tz    <= n_tz;
                    r_nz    <= n_nz;
                    r_dc    <= n_dc;
                    r_idc   <= n_idc;
                end
            end
            if (take && i_q_item.last) begin
                r_snap_vld <= 1'b1;
            end else if (o_res_push) begin
                r_snap_vld <= 1'b0;
            end
        end
    end

    // judgement on the captured word
    logic [2:0]    lim;
    logic [CW-1:0] all_d, sig_d, lead_d, trail_d;
    logic [CW:0]   total;
    logic          bad;

    always_comb begin
        lim   = frac_limit(i_cfg.incr_code);
        all_d = sat_sub(r_snap.dc, r_snap.tz);
        sig_d = sat_sub(all_d, r_snap.lz);
        bad   = r_snap.err || (r_snap.dc == '0) || (!i_cfg.allow_lz && r_snap.lz != '0);
        if (!r_snap.pt) begin
            lead_d  = sig_d;
            trail_d = '0;
            if (lead_d != '0 && i_cfg.implied) begin
                if (lim == 3'd0) begin
                    bad = 1'b1;
                end
                trail_d = CW'(lim);
            end
        end else begin
            lead_d  = r_snap.idc;
            trail_d = sat_sub(sig_d, r_snap.idc);
            if (lim == 3'd0 || 32'(trail_d) > 32'(lim)) begin
                bad = 1'b1;
            end
        end
        total = (CW + 1)'(lead_d) + (CW + 1)'(trail_d);
        if (total != '0 && (32'(total) > 32'(i_cfg.max_digits)
                            || 32'(total) < 32'(i_cfg.min_digits))) begin
            bad = 1'b1;
        end
        o_res.word_valid = !bad;
        o_res.point_seen = !bad && r_snap.pt;
        if (bad) begin
            o_res.significant_digits = '0;
        end else if (32'(total) > 32'(SIG_MAX)) begin
            o_res.significant_digits = SIG_W'(SIG_MAX);
        end else begin
            o_res.significant_digits = SIG_W'(total);
        end
    end

endmodule

/* hdl/nc_decimal_word_verifier.sv */
// Top level of the decimal word verifier: configuration registers and stage wiring.
//
// Usage:
//   Characters of a program word enter as requests on the input queue side:
//   a request is taken at a rising edge with push high and full low. Mark the
//   final character of a word with i_last_char; only that character produces
//   a result. Results leave on the output queue side: while empty is low the
//   oldest result sits on o_word_valid / o_point_seen / o_significant_digits
//   and is taken at an edge with pop high.
//   Throughput: one character per cycle sustained while full stays low. Each
//   character passes a classify register, a two-entry work queue and the
//   counter stage; the last one of a word also fills the snapshot register.
//   The judgement stage reads that register. Stalls: if pop is held low,
//   results collect in the output queue, then the snapshot register; characters
//   then fill the work queue and the classify register, and only then does
//   full rise.
//   Reset (synchronous, i_rst_n low) empties all queues, clears the word
//   state and loads the register defaults. Configuration writes are taken
//   at once and should only be made while no word is in flight.
module nc_decimal_word_verifier import dwv_pkg::*; #(
    parameter int MAX_COUNT = DEFAULT_MAX_COUNT,
    parameter int Q_DEPTH   = DEFAULT_Q_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // character requests
    input  logic                  push,
    output logic                  full,
    input  logic [7:0]            i_char_code,
    input  logic                  i_last_char,
    // result requests
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_word_valid,
    output logic                  o_point_seen,
    output logic [SIG_W-1:0]      o_significant_digits
);
    localparam int ITEM_W = $bits(t_char_item);
    localparam int RES_W  = $bits(t_result);

    t_cfg r_cfg;

    // register file; indexes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.allow_lz   <= 1'b1;
            r_cfg.implied    <= 1'b0;
            r_cfg.incr_code  <= INCR_0_001;
            r_cfg.max_digits <= CFG_DATA_W'(8);
            r_cfg.min_digits <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_ALLOW_LZ:   r_cfg.allow_lz   <= i_cfg_data[0];
                CFG_IMPLIED:    r_cfg.implied    <= i_cfg_data[0];
                CFG_INCR_CODE:  r_cfg.incr_code  <= i_cfg_data[1:0];
                CFG_MAX_DIGITS: r_cfg.max_digits <= i_cfg_data;
                CFG_MIN_DIGITS: r_cfg.min_digits <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front -> work queue
    logic       wq_push, wq_full, wq_pop, wq_empty;
    t_char_item wq_in, wq_out;

    dwv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .o_full      (full),
        .o_q_push    (wq_push),
        .o_q_item    (wq_in),
        .i_q_full    (wq_full)
    );

    dwv_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (Q_DEPTH)
    ) u_work_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (wq_push),
        .i_data  (wq_in),
        .o_full  (wq_full),
        .i_pop   (wq_pop),
        .o_data  (wq_out),
        .o_empty (wq_empty)
    );

    // back end -> result queue
    logic    rq_push, rq_full;
    t_result rq_in, rq_out;

    dwv_back #(
        .MAX_COUNT (MAX_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (wq_empty),
        .i_q_item   (wq_out),
        .o_q_pop    (wq_pop),
        .o_res_push (rq_push),
        .o_res      (rq_in),
        .i_res_full (rq_full)
    );

    dwv_fifo #(
        .WIDTH (RES_W),
        .DEPTH (Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_data  (rq_in),
        .o_full  (rq_full),
        .i_pop   (pop),
        .o_data  (rq_out),
        .o_empty (empty)
    );

    assign o_word_valid         = rq_out.word_valid;
    assign o_point_seen         = rq_out.point_seen;
    assign o_significant_digits = rq_out.significant_digits;

endmodule
